// ----- rtl/core/lbm_d3q7_pkg.sv -----
// lbm_d3q7_pkg: action codes, result kinds, lane indexes and saturation helper
// for the d3q7 lattice-Boltzmann step engine; no dependencies
`timescale 1ns / 1ps

package lbm_d3q7_pkg;

    localparam int NDIR  = 7;
    localparam int DW    = 32;
    localparam int RW    = 18;
    localparam int RLANES = 3;

    localparam logic [RW-1:0] RATE_RESET = 18'd65536;

    typedef enum logic [2:0] {
        ACT_WR_DIST = 3'd0,
        ACT_WR_RHO  = 3'd1,
        ACT_WR_SRC  = 3'd2,
        ACT_ITERATE = 3'd3,
        ACT_RD_DIST = 3'd4,
        ACT_RD_RHO  = 3'd5,
        ACT_RD_SRC  = 3'd6,
        ACT_NOP     = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        K_ZERO = 3'd0,
        K_DIST = 3'd1,
        K_RHO  = 3'd2,
        K_SRC  = 3'd3,
        K_STEP = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    // lane 2 of a density row holds the source, lanes 0 and 1 the two density banks
    localparam logic [1:0] RL_SRC = 2'd2;
    localparam logic [2:0] DIR_LAST = 3'd6;

    function automatic logic signed [DW-1:0] sat32(input logic signed [37:0] v);
        logic signed [37:0] hi;
        logic signed [37:0] lo;
        hi = 38'sd2147483647;
        lo = -38'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[DW-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/lattice_boltzmann_d3q7_step.sv -----
// lattice_boltzmann_d3q7_step: periodic d3q7 bgk grid with host access and
// a fused collide/stream/density sweep over double-banked memories
// depends on lbm_d3q7_pkg
//
// channel   dir  handshake                    payload
// in        in   i_in_valid / o_in_ready      action, cell_x/y/z, direction, write_value
// out       out  o_out_valid / i_out_ready    read_value, step_done
// cfg       in   i_cfg_we                     relax_rate
//
// host reads and writes give one result per request
// an iterate request sweeps one (cell, direction)
// pair per cycle through the single distribution memory write port
// after reset a clearing pass over all 2**(address bits) cell addresses (4096 by default) runs
// before the first request is taken
// a stalled result holds its stage; new requests wait until that stage can move
`timescale 1ns / 1ps

module lattice_boltzmann_d3q7_step
    import lbm_d3q7_pkg::*;
#(
    parameter int X_SIZE = 16,
    parameter int Y_SIZE = 16,
    parameter int Z_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_action,
    input  logic [3:0]           i_cell_x,
    input  logic [3:0]           i_cell_y,
    input  logic [3:0]           i_cell_z,
    input  logic [2:0]           i_direction,
    input  logic signed [31:0]   i_write_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_read_value,
    output logic                 o_step_done,
    input  logic                 i_cfg_we,
    input  logic [RW-1:0]        i_cfg_wdata
);

    localparam int XW = $clog2(X_SIZE);
    localparam int YW = $clog2(Y_SIZE);
    localparam int ZW = $clog2(Z_SIZE);
    localparam int AW = XW + YW + ZW;
    localparam int CDEPTH = 1 << AW;
    localparam int FDEPTH = 2 * CDEPTH;
    localparam logic [XW-1:0] XMAX = XW'(X_SIZE - 1);
    localparam logic [YW-1:0] YMAX = YW'(Y_SIZE - 1);
    localparam logic [ZW-1:0] ZMAX = ZW'(Z_SIZE - 1);

    logic [NDIR-1:0][DW-1:0]   r_fmem [FDEPTH];
    logic [RLANES-1:0][DW-1:0] r_rmem [CDEPTH];
    logic [NDIR-1:0][DW-1:0]   r_frd;
    logic [RLANES-1:0][DW-1:0] r_rrd;

    t_state            r_state, n_state;
    logic              r_bank;
    logic [RW-1:0]     r_rate;
    logic [AW-1:0]     r_clr;
    logic [AW-1:0]     r_haddr;

    logic [XW-1:0]     r_sx;
    logic [YW-1:0]     r_sy;
    logic [ZW-1:0]     r_sz;
    logic [2:0]        r_sd;

    logic              r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic [2:0]        r_p1_d, r_p2_d, r_p3_d, r_p4_d;
    logic [AW-1:0]     r_p1_a, r_p2_a, r_p3_a, r_p4_a;
    logic signed [DW-1:0] r_p2_f, r_p2_s, r_p3_f, r_p3_s, r_p4_val;
    logic signed [DW:0]   r_p2_diff;
    logic signed [51:0]   r_p3_prod;
    logic signed [34:0]   r_acc;

    logic              r_s1_valid;
    t_kind             r_s1_kind;
    logic [2:0]        r_s1_d;
    logic              r_out_valid;
    logic signed [DW-1:0] r_out_value;
    logic              r_out_step;

    logic              in_acc, out_free, s1_adv, sweep_last, drain_done;
    logic              in_grid, dir_ok;
    t_action           act;
    logic [AW-1:0]     host_addr, src_addr, raddr;
    logic [XW-1:0]     sxm, sxp, srcx;
    logic [YW-1:0]     sym, syp, srcy;
    logic [ZW-1:0]     szm, szp, srcz;
    logic signed [DW-1:0] p1_f, p1_rho, p1_src, p1_eq, p1_s;
    logic signed [37:0]   p3_sum;
    logic signed [34:0]   p4_acc;
    logic signed [DW-1:0] s1_value;

    logic              f_we, f_clear;
    logic [AW:0]       f_waddr;
    logic [2:0]        f_wlane;
    logic signed [DW-1:0] f_wdata;
    logic              r_we, r_clear;
    logic [AW-1:0]     r_waddr;
    logic [1:0]        r_wlane;
    logic signed [DW-1:0] r_wdata;

    assign act       = t_action'(i_action);
    assign in_grid   = (32'(i_cell_x) < X_SIZE) && (32'(i_cell_y) < Y_SIZE)
                       && (32'(i_cell_z) < Z_SIZE);
    assign dir_ok    = (32'(i_direction) < NDIR);
    assign host_addr = {XW'(i_cell_x), YW'(i_cell_y), ZW'(i_cell_z)};

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = (r_state == ST_IDLE) && (!r_s1_valid || out_free);
    assign in_acc     = i_in_valid && o_in_ready;
    assign sweep_last = (r_sx == XMAX) && (r_sy == YMAX) && (r_sz == ZMAX)
                        && (r_sd == DIR_LAST);
    assign drain_done = !r_p1_v && !r_p2_v && !r_p3_v && !r_p4_v;

    // pull source cell for the current destination and direction
    always_comb begin
        sxm = (r_sx == '0) ? XMAX : r_sx - 1'b1;
        sxp = (r_sx == XMAX) ? '0 : r_sx + 1'b1;
        sym = (r_sy == '0) ? YMAX : r_sy - 1'b1;
        syp = (r_sy == YMAX) ? '0 : r_sy + 1'b1;
        szm = (r_sz == '0) ? ZMAX : r_sz - 1'b1;
        szp = (r_sz == ZMAX) ? '0 : r_sz + 1'b1;
        srcx = r_sx;
        srcy = r_sy;
        srcz = r_sz;
        case (r_sd)
            3'd1:    srcx = sxm;
            3'd2:    srcy = sym;
            3'd3:    srcx = sxp;
            3'd4:    srcy = syp;
            3'd5:    srcz = szm;
            3'd6:    srcz = szp;
            default: srcx = r_sx;
        endcase
        src_addr = {srcx, srcy, srcz};
    end

    always_comb begin
        if (r_state == ST_SWEEP) begin
            raddr = src_addr;
        end else if (in_acc) begin
            raddr = host_addr;
        end else begin
            raddr = r_haddr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frd <= r_fmem[{r_bank, raddr}];
        r_rrd <= r_rmem[raddr];
        if (f_we) begin
            if (f_clear) begin
                r_fmem[f_waddr] <= '0;
            end else begin
                r_fmem[f_waddr][f_wlane] <= f_wdata;
            end
        end
        if (r_we) begin
            if (r_clear) begin
                r_rmem[r_waddr] <= '0;
            end else begin
                r_rmem[r_waddr][r_wlane] <= r_wdata;
            end
        end
    end

    // collision datapath
    always_comb begin
        p1_f   = r_frd[r_p1_d];
        p1_rho = r_rrd[{1'b0, r_bank}];
        p1_src = r_rrd[RL_SRC];
        p1_eq  = (r_p1_d == '0) ? (p1_rho >>> 2) : (p1_rho >>> 3);
        p1_s   = (r_p1_d == '0) ? (p1_src >>> 2) : (p1_src >>> 3);
        p3_sum = 38'(r_p3_f) + 38'(r_p3_prod >>> 16) + 38'(r_p3_s);
        p4_acc = ((r_p4_d == '0) ? 35'sd0 : r_acc) + 35'(r_p4_val);
    end

    always_ff @(posedge i_clk) begin
        r_p2_f    <= p1_f;
        r_p2_s    <= p1_s;
        r_p2_diff <= 33'(p1_eq) - 33'(p1_f);
        r_p3_f    <= r_p2_f;
        r_p3_s    <= r_p2_s;
        r_p3_prod <= 52'($signed({1'b0, r_rate}) * r_p2_diff);
        r_p4_val  <= sat32(p3_sum);
        if (r_p4_v) begin
            r_acc <= p4_acc;
        end
        r_p1_d <= r_sd;
        r_p1_a <= {r_sx, r_sy, r_sz};
        r_p2_d <= r_p1_d;
        r_p2_a <= r_p1_a;
        r_p3_d <= r_p2_d;
        r_p3_a <= r_p2_a;
        r_p4_d <= r_p3_d;
        r_p4_a <= r_p3_a;
    end

    // write port selection
    always_comb begin
        f_we    = 1'b0;
        f_clear = 1'b0;
        f_waddr = {r_bank, host_addr};
        f_wlane = i_direction;
        f_wdata = i_write_value;
        r_we    = 1'b0;
        r_clear = 1'b0;
        r_waddr = host_addr;
        r_wlane = {1'b0, r_bank};
        r_wdata = i_write_value;
        if (r_state == ST_CLEAR) begin
            f_we    = 1'b1;
            f_clear = 1'b1;
            f_waddr = {1'b0, r_clr};
            r_we    = 1'b1;
            r_clear = 1'b1;
            r_waddr = r_clr;
        end else if (r_p4_v) begin
            f_we    = 1'b1;
            f_waddr = {~r_bank, r_p4_a};
            f_wlane = r_p4_d;
            f_wdata = r_p4_val;
            r_we    = (r_p4_d == DIR_LAST);
            r_waddr = r_p4_a;
            r_wlane = {1'b0, ~r_bank};
            r_wdata = sat32(38'(p4_acc));
        end else if (in_acc && in_grid) begin
            unique case (act)
                ACT_WR_DIST: f_we = dir_ok;
                ACT_WR_RHO:  r_we = 1'b1;
                ACT_WR_SRC: begin
                    r_we    = 1'b1;
                    r_wlane = RL_SRC;
                end
                default:     f_we = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE:  if (in_acc && act == ACT_ITERATE) n_state = ST_SWEEP;
            ST_SWEEP: if (sweep_last) n_state = ST_DRAIN;
            ST_DRAIN: if (drain_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_s1_kind)
            K_DIST:  s1_value = r_frd[r_s1_d];
            K_RHO:   s1_value = r_rrd[{1'b0, r_bank}];
            K_SRC:   s1_value = r_rrd[RL_SRC];
            default: s1_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_bank      <= 1'b0;
            r_rate      <= RATE_RESET;
            r_clr       <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sz        <= '0;
            r_sd        <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p3_v      <= 1'b0;
            r_p4_v      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s1_kind   <= K_ZERO;
            r_out_valid <= 1'b0;
            r_haddr     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (in_acc) begin
                r_haddr <= host_addr;
            end
            if (r_state == ST_SWEEP) begin
                if (r_sd == DIR_LAST) begin
                    r_sd <= '0;
                    if (r_sz == ZMAX) begin
                        r_sz <= '0;
                        if (r_sy == YMAX) begin
                            r_sy <= '0;
                            r_sx <= (r_sx == XMAX) ? '0 : r_sx + 1'b1;
                        end else begin
                            r_sy <= r_sy + 1'b1;
                        end
                    end else begin
                        r_sz <= r_sz + 1'b1;
                    end
                end else begin
                    r_sd <= r_sd + 1'b1;
                end
            end
            r_p1_v <= (r_state == ST_SWEEP);
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            if (r_state == ST_DRAIN && drain_done) begin
                r_bank     <= ~r_bank;
                r_s1_valid <= 1'b1;
                r_s1_kind  <= K_STEP;
            end else if (in_acc && act != ACT_ITERATE) begin
                r_s1_valid <= 1'b1;
                r_s1_d     <= i_direction;
                if (in_grid && act == ACT_RD_DIST && dir_ok) begin
                    r_s1_kind <= K_DIST;
                end else if (in_grid && act == ACT_RD_RHO) begin
                    r_s1_kind <= K_RHO;
                end else if (in_grid && act == ACT_RD_SRC) begin
                    r_s1_kind <= K_SRC;
                end else begin
                    r_s1_kind <= K_ZERO;
                end
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_out_value <= s1_value;
                r_out_step  <= (r_s1_kind == K_STEP);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_step_done  = r_out_step;

    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !r_s1_valid)
        else $error("result stage busy during sweep");

    a_pipe_only_sweeping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p4_v |-> (r_state == ST_SWEEP || r_state == ST_DRAIN))
        else $error("collision write outside sweep");

    a_step_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_step_done) |-> (o_read_value == '0))
        else $error("iterate result carries data");

endmodule

// ----- test/lattice_boltzmann_d3q7_step_tb.sv -----
// lattice_boltzmann_d3q7_step_tb: self-checking bench for the d3q7 grid engine
// drives host and iterate requests through bursty handshakes, predicts each result
// with an in-bench grid image; depends on lbm_d3q7_pkg and the step engine
`timescale 1ns / 1ps

module lattice_boltzmann_d3q7_step_tb;
    import lbm_d3q7_pkg::*;

    localparam int GRID = 16;
    localparam int NCELLS = GRID * GRID * GRID;
    localparam int MAX_ITER = 14;

    typedef struct {
        t_action                act;
        logic [3:0]             cx;
        logic [3:0]             cy;
        logic [3:0]             cz;
        logic [2:0]             dir;
        logic signed [31:0]     wval;
    } t_request;

    typedef struct {
        logic signed [31:0]     rval;
        logic                   done;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [2:0]           i_action = 3'd0;
    logic [3:0]           i_cell_x = 4'd0;
    logic [3:0]           i_cell_y = 4'd0;
    logic [3:0]           i_cell_z = 4'd0;
    logic [2:0]           i_direction = 3'd0;
    logic signed [31:0]   i_write_value = 32'sd0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [31:0]   o_read_value;
    logic                 o_step_done;
    logic                 i_cfg_we = 1'b0;
    logic [RW-1:0]        i_cfg_wdata = '0;

    lattice_boltzmann_d3q7_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_action(i_action), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_cell_z(i_cell_z), .i_direction(i_direction), .i_write_value(i_write_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_read_value(o_read_value), .o_step_done(o_step_done),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // grid image
    logic signed [31:0] grid_f[NDIR][NCELLS];
    logic signed [31:0] grid_rho[NCELLS];
    logic signed [31:0] grid_src[NCELLS];
    logic signed [31:0] shift_buf[NCELLS];
    logic [RW-1:0]      rate;

    t_request pending[$];
    t_answer  expected[$];
    int mismatches = 0;
    int answers_seen = 0;
    int iterations = 0;
    int stall_pct = 0;
    bit sender_hold = 1'b0;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int cell_of(input int x, input int y, input int z);
        return (x * GRID + y) * GRID + z;
    endfunction

    function automatic void lattice_step();
        int dx[NDIR];
        int dy[NDIR];
        int dz[NDIR];
        longint f;
        longint eqv;
        longint srcv;
        longint rel;
        longint sum;
        dx = '{0, 1, 0, -1, 0, 0, 0};
        dy = '{0, 0, 1, 0, -1, 0, 0};
        dz = '{0, 0, 0, 0, 0, 1, -1};
        for (int c = 0; c < NCELLS; c++) begin
            for (int d = 0; d < NDIR; d++) begin
                f = grid_f[d][c];
                eqv = longint'(grid_rho[c]) >>> (d == 0 ? 2 : 3);
                srcv = longint'(grid_src[c]) >>> (d == 0 ? 2 : 3);
                rel = (longint'(rate) * (eqv - f)) >>> 16;
                grid_f[d][c] = clip32(f + rel + srcv);
            end
        end
        for (int d = 1; d < NDIR; d++) begin
            for (int c = 0; c < NCELLS; c++) shift_buf[c] = grid_f[d][c];
            for (int x = 0; x < GRID; x++)
                for (int y = 0; y < GRID; y++)
                    for (int z = 0; z < GRID; z++)
                        grid_f[d][cell_of(x, y, z)] = shift_buf[cell_of(
                            (x - dx[d] + GRID) % GRID, (y - dy[d] + GRID) % GRID,
                            (z - dz[d] + GRID) % GRID)];
        end
        for (int c = 0; c < NCELLS; c++) begin
            sum = 0;
            for (int d = 0; d < NDIR; d++) sum += grid_f[d][c];
            grid_rho[c] = clip32(sum);
        end
    endfunction

    function automatic t_answer apply_request(input t_request r);
        t_answer a;
        int c;
        c = cell_of(r.cx, r.cy, r.cz);
        a.rval = 32'sd0;
        a.done = 1'b0;
        case (r.act)
            ACT_WR_DIST: if (r.dir < NDIR) grid_f[r.dir][c] = r.wval;
            ACT_WR_RHO:  grid_rho[c] = r.wval;
            ACT_WR_SRC:  grid_src[c] = r.wval;
            ACT_ITERATE: begin
                lattice_step();
                a.done = 1'b1;
            end
            ACT_RD_DIST: if (r.dir < NDIR) a.rval = grid_f[r.dir][c];
            ACT_RD_RHO:  a.rval = grid_rho[c];
            ACT_RD_SRC:  a.rval = grid_src[c];
            default: ;
        endcase
        return a;
    endfunction

    // driver
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_request nxt;
        logic busy;
        busy = i_in_valid;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected.push_back(apply_request(pending.pop_front()));
            busy = 1'b0;
        end
        if (!busy) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending.size() > 0 && i_rst_n && !sender_hold) begin
                nxt = pending[0];
                i_in_valid <= 1'b1;
                i_action <= nxt.act;
                i_cell_x <= nxt.cx;
                i_cell_y <= nxt.cy;
                i_cell_z <= nxt.cz;
                i_direction <= nxt.dir;
                i_write_value <= nxt.wval;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    int rx_cycle = 0;
    always @(posedge i_clk) begin
        t_answer e;
        rx_cycle <= rx_cycle + 1;
        i_out_ready <= (rx_cycle % 11 < 3) ? ($urandom_range(0, 99) >= 70)
                                           : ($urandom_range(0, 99) >= stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            answers_seen++;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: read_value %h step_done %b",
                             o_read_value, o_step_done);
            end else begin
                e = expected.pop_front();
                if (o_read_value !== e.rval || o_step_done !== e.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: read_value exp %h got %h, step_done exp %b got %b",
                                 e.rval, o_read_value, e.done, o_step_done);
                end
            end
        end
    end

    task automatic add_request(input t_action act, input int x, input int y, input int z,
                               input int dir, input logic signed [31:0] wv);
        t_request r;
        r.act = act;
        r.cx = 4'(x);
        r.cy = 4'(y);
        r.cz = 4'(z);
        r.dir = 3'(dir);
        r.wval = wv;
        if (act == ACT_ITERATE) iterations++;
        pending.push_back(r);
    endtask

    task automatic drain_all();
        while (pending.size() > 0 || i_in_valid || expected.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // sender held: wait for the request in flight and every result still owed
    task automatic wait_results();
        @(posedge i_clk);
        while (i_in_valid || expected.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_rate(input logic [RW-1:0] v);
        drain_all();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        rate = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int count);
        int hx[$];
        int sel;
        int c;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 199);
            if (sel < 2 && iterations < MAX_ITER) begin
                add_request(ACT_ITERATE, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 7), $urandom);
            end else if (sel < 90) begin
                c = $urandom_range(0, NCELLS - 1);
                hx.push_back(c);
                add_request(t_action'($urandom_range(0, 2)), c / 256, (c / 16) % 16, c % 16,
                            $urandom_range(0, 7), pick_value());
            end else if (sel < 195) begin
                c = (hx.size() > 0 && $urandom_range(0, 1)) ? hx[$urandom_range(0, hx.size() - 1)]
                                                           : $urandom_range(0, NCELLS - 1);
                add_request(t_action'($urandom_range(4, 6)), c / 256, (c / 16) % 16, c % 16,
                            $urandom_range(0, 7), $urandom);
            end else begin
                add_request(ACT_NOP, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 7), $urandom);
            end
        end
    endtask

    initial begin
        logic [RW-1:0] rates[5];
        for (int c = 0; c < NCELLS; c++) begin
            grid_rho[c] = 0;
            grid_src[c] = 0;
            for (int d = 0; d < NDIR; d++) grid_f[d][c] = 0;
        end
        rate = RATE_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every action, bad direction, idle action, saturation
        add_request(ACT_RD_DIST, 0, 0, 0, 0, 0);
        add_request(ACT_WR_DIST, 0, 0, 0, 0, 32'sh7fffffff);
        add_request(ACT_WR_DIST, 15, 15, 15, 6, 32'sh80000000);
        add_request(ACT_WR_DIST, 3, 4, 5, 7, 32'sh12345678);
        add_request(ACT_RD_DIST, 3, 4, 5, 7, 0);
        add_request(ACT_WR_RHO, 0, 0, 0, 0, 32'sh7fffffff);
        add_request(ACT_WR_RHO, 15, 15, 15, 0, 32'sh80000000);
        add_request(ACT_WR_SRC, 0, 0, 0, 0, 32'sh7fffffff);
        add_request(ACT_WR_SRC, 15, 0, 15, 0, -32'sd65536);
        add_request(ACT_WR_DIST, 1, 2, 3, 1, 32'sh0001_8000);
        add_request(ACT_RD_DIST, 0, 0, 0, 0, 0);
        add_request(ACT_RD_DIST, 15, 15, 15, 6, 0);
        add_request(ACT_RD_RHO, 15, 15, 15, 0, 0);
        add_request(ACT_RD_SRC, 15, 0, 15, 0, 0);
        add_request(ACT_NOP, 7, 7, 7, 3, 32'shffffffff);
        add_request(ACT_ITERATE, 0, 0, 0, 0, 0);
        add_request(ACT_RD_DIST, 1, 0, 0, 1, 0);
        add_request(ACT_RD_DIST, 15, 15, 0, 6, 0);
        add_request(ACT_RD_DIST, 2, 3, 3, 1, 0);
        add_request(ACT_RD_RHO, 0, 0, 0, 0, 0);
        add_request(ACT_RD_RHO, 15, 15, 15, 0, 0);
        add_request(ACT_RD_DIST, 0, 0, 0, 0, 0);

        rates = '{18'd0, 18'd131072, 18'h3ffff, 18'd1, 18'd65536};
        for (int p = 0; p < 5; p++) begin
            stall_pct = (p == 2) ? 0 : $urandom_range(5, 60);
            if (p == 3) begin
                sender_hold = 1'b1;
                wait_results();
                sender_hold = 1'b0;
            end
            set_rate(p == 4 ? 18'($urandom_range(0, 18'h3ffff)) : rates[p]);
            random_phase(346);
            if (p == 1) begin
                set_rate(rates[4]);
                random_phase(10);
            end
        end
        drain_all();
        repeat (20) @(posedge i_clk);
        $display("covered %0d results, %0d grid iterations, relax rates from 0 to 18'h3ffff",
                 answers_seen, iterations);
        $display("mismatching results: %0d, left over: %0d", mismatches, expected.size());
        if (mismatches == 0 && expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/lbm_d3q7_pkg.sv
rtl/core/lattice_boltzmann_d3q7_step.sv
test/lattice_boltzmann_d3q7_step_tb.sv
